>>> rtl/double_ended_queue_top_defines.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared concurrent assertion wrappers used by the queue RTL.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Assertion sampled on the rising clock edge and disabled while in reset.
`define DEQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Assertion sampled on the rising clock edge that also holds during reset.
`define DEQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> rtl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Command and status codes, controller states and the control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

    // Default number of entries in the ring store.
    localparam int unsigned DEPTH_DEFAULT = 16;

    // Width of a stored value.
    localparam int unsigned DATA_W = 32;

    // Width of the command field.
    localparam int unsigned CMD_W = 3;

    // Width of the status field.
    localparam int unsigned STATUS_W = 2;

    // Commands carried by an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_CLEAR      = 3'd4
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;   // capture the accepted request
        logic exec;      // apply the command to the queue
        logic load_out;  // load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid; // result register holds an untaken result
        logic out_take;  // result is taken in this cycle
    } dp_sts_t;

endpackage

`default_nettype wire

>>> rtl/deq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/deq_ctrl.sv
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences each request through accept, execute and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire deq_pkg::dp_sts_t  dp_sts,
    output deq_pkg::dp_cmd_t       dp_cmd
);

    deq_pkg::state_t state_reg;
    deq_pkg::state_t state_next;
    logic            out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !dp_sts.out_valid || dp_sts.out_take;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= deq_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            deq_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = deq_pkg::ST_EXEC;
                end
            end
            deq_pkg::ST_EXEC: begin
                state_next = deq_pkg::ST_LOAD;
            end
            deq_pkg::ST_LOAD: begin
                if (out_free) begin
                    state_next = deq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = deq_pkg::ST_IDLE;
            end
        endcase
    end

    // Output logic.
    always_comb begin
        s_tready        = 1'b0;
        dp_cmd.load_in  = 1'b0;
        dp_cmd.exec     = 1'b0;
        dp_cmd.load_out = 1'b0;
        case (state_reg)
            deq_pkg::ST_IDLE: begin
                s_tready       = 1'b1;
                dp_cmd.load_in = s_tvalid;
            end
            deq_pkg::ST_EXEC: begin
                dp_cmd.exec = 1'b1;
            end
            deq_pkg::ST_LOAD: begin
                dp_cmd.load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/deq_dpath.sv
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring pointers, entry count, ring store and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "double_ended_queue_top_defines.svh"

module deq_dpath #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire deq_pkg::dp_cmd_t                      dp_cmd,
    output deq_pkg::dp_sts_t                           dp_sts,
    input  wire logic [deq_pkg::CMD_W-1:0]             in_command,
    input  wire logic signed [deq_pkg::DATA_W-1:0]     in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic signed [deq_pkg::DATA_W-1:0]          out_data,
    output logic [deq_pkg::STATUS_W-1:0]               out_status,
    output logic [$clog2(DEPTH+1)-1:0]                 out_count,
    output logic                                       out_empty
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Captured request.
    deq_pkg::cmd_t                    cmd_reg;
    logic signed [deq_pkg::DATA_W-1:0] data_reg;

    // Queue state.
    logic [IW-1:0] front_reg, front_next;
    logic [IW-1:0] back_reg, back_next;
    logic [CW-1:0] count_reg, count_next;

    // Per-request results held until the result load.
    deq_pkg::status_t status_reg, status_next;
    logic             pop_ok_reg, pop_ok_next;

    // Result register.
    logic                              out_valid_reg;
    logic signed [deq_pkg::DATA_W-1:0] out_data_reg;
    deq_pkg::status_t                  out_status_reg;
    logic [CW-1:0]                     out_count_reg;

    // Ring store ports.
    logic                       ram_we;
    logic [IW-1:0]              ram_waddr;
    logic                       ram_re;
    logic [IW-1:0]              ram_raddr;
    logic [deq_pkg::DATA_W-1:0] ram_rdata;

    logic          is_full;
    logic          is_empty;
    logic [IW-1:0] front_up, front_down;
    logic [IW-1:0] back_up, back_down;

    // Conditions watched by the checks at the end.
    logic          cnt_at_limit;
    logic          exec_clear;
    logic          exec_pop_empty;

    // Capture the accepted request.
    always_ff @(posedge aclk) begin
        if (dp_cmd.load_in) begin
            cmd_reg  <= deq_pkg::cmd_t'(in_command);
            data_reg <= in_data;
        end
    end

    // Ring index steps with wrap at the store depth.
    assign front_up   = (front_reg == LAST_IDX) ? '0 : front_reg + IW'(1);
    assign front_down = (front_reg == '0) ? LAST_IDX : front_reg - IW'(1);
    assign back_up    = (back_reg == LAST_IDX) ? '0 : back_reg + IW'(1);
    assign back_down  = (back_reg == '0) ? LAST_IDX : back_reg - IW'(1);

    assign is_full  = (count_reg == FULL_CNT);
    assign is_empty = (count_reg == '0);

    // Command decode: at most one store access and the pointer updates.
    always_comb begin
        front_next  = front_reg;
        back_next   = back_reg;
        count_next  = count_reg;
        status_next = deq_pkg::STATUS_OK;
        pop_ok_next = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = back_reg;
        ram_re      = 1'b0;
        ram_raddr   = front_reg;
        case (cmd_reg)
            deq_pkg::CMD_PUSH_FRONT: begin
                if (is_full) begin
                    status_next = deq_pkg::STATUS_FULL;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = front_down;
                    front_next = front_down;
                    count_next = count_reg + CW'(1);
                end
            end
            deq_pkg::CMD_PUSH_BACK: begin
                if (is_full) begin
                    status_next = deq_pkg::STATUS_FULL;
                end else begin
                    ram_we     = 1'b1;
                    ram_waddr  = back_reg;
                    back_next  = back_up;
                    count_next = count_reg + CW'(1);
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (is_empty) begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end else begin
                    ram_re      = 1'b1;
                    ram_raddr   = front_reg;
                    front_next  = front_up;
                    count_next  = count_reg - CW'(1);
                    pop_ok_next = 1'b1;
                end
            end
            deq_pkg::CMD_POP_BACK: begin
                if (is_empty) begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end else begin
                    ram_re      = 1'b1;
                    ram_raddr   = back_down;
                    back_next   = back_down;
                    count_next  = count_reg - CW'(1);
                    pop_ok_next = 1'b1;
                end
            end
            deq_pkg::CMD_CLEAR: begin
                front_next = '0;
                back_next  = '0;
                count_next = '0;
            end
            default: begin
                // Unknown commands leave the queue untouched.
                status_next = deq_pkg::STATUS_OK;
            end
        endcase
    end

    // Queue state registers, cleared by reset and otherwise updated only while executing.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg <= '0;
            back_reg  <= '0;
            count_reg <= '0;
        end else if (dp_cmd.exec) begin
            front_reg <= front_next;
            back_reg  <= back_next;
            count_reg <= count_next;
        end
    end

    // Per-request outcome.
    always_ff @(posedge aclk) begin
        if (dp_cmd.exec) begin
            status_reg <= status_next;
            pop_ok_reg <= pop_ok_next;
        end
    end

    // Ring store.
    deq_ram #(
        .WIDTH (deq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we && dp_cmd.exec),
        .wr_addr (ram_waddr),
        .wr_data (data_reg),
        .rd_en   (ram_re && dp_cmd.exec),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Result valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (dp_cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge aclk) begin
        if (dp_cmd.load_out) begin
            out_data_reg   <= pop_ok_reg ? ram_rdata : '0;
            out_status_reg <= status_reg;
            out_count_reg  <= count_reg;
        end
    end

    assign dp_sts.out_valid = out_valid_reg;
    assign dp_sts.out_take  = out_valid_reg && out_ready;

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign out_status = out_status_reg;
    assign out_count  = out_count_reg;
    assign out_empty  = (out_count_reg == '0);

    // Conditions for the bookkeeping checks.
    assign cnt_at_limit   = (count_reg == '0) || (count_reg == FULL_CNT);
    assign exec_clear     = dp_cmd.exec && (cmd_reg == deq_pkg::CMD_CLEAR);
    assign exec_pop_empty = dp_cmd.exec && is_empty &&
                            (cmd_reg == deq_pkg::CMD_POP_FRONT ||
                             cmd_reg == deq_pkg::CMD_POP_BACK);

    // Checks on the queue bookkeeping.
    `DEQ_ASSERT_RST(a_count_bound, count_reg <= FULL_CNT, "entry count exceeds depth")
    `DEQ_ASSERT_RST(a_ptr_meet, cnt_at_limit |-> front_reg == back_reg, "pointer mismatch")
    `DEQ_ASSERT_RST(a_clear, exec_clear |=> count_reg == '0, "clear left entries")
    `DEQ_ASSERT_RST(a_empty_pop, exec_pop_empty |=> $stable(count_reg), "empty pop changed queue")

endmodule

`default_nettype wire

>>> rtl/double_ended_queue_top.sv
// The controller takes one request at a time through its three-step sequence
// (accept, store access, result load) and takes no new request until the result
// register has been loaded. A stalled result keeps the controller in the
// result-load step and holds off further requests.
// Reset (aresetn low, synchronous) empties the queue; store contents need no clearing.
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Bounded deque of signed 32-bit values on streaming request/result channels.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    // s_tdata: [2:0] command, [34:3] data_in, upper bits zero fill
    input  wire logic [((deq_pkg::CMD_W + deq_pkg::DATA_W + 7) / 8) * 8 - 1:0] s_tdata,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // m_tdata: [31:0] data_out, [33:32] status, then entry_count, then is_empty,
    // upper bits zero fill
    output logic [((deq_pkg::DATA_W + deq_pkg::STATUS_W + $clog2(DEPTH + 1) + 1 + 7) / 8)
                  * 8 - 1:0] m_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready
);

    localparam int unsigned CW      = $clog2(DEPTH + 1);
    localparam int unsigned M_RAW_W = deq_pkg::DATA_W + deq_pkg::STATUS_W + CW + 1;
    localparam int unsigned M_W     = ((M_RAW_W + 7) / 8) * 8;

    deq_pkg::dp_cmd_t dp_cmd;
    deq_pkg::dp_sts_t dp_sts;

    logic signed [deq_pkg::DATA_W-1:0] out_data;
    logic [deq_pkg::STATUS_W-1:0]      out_status;
    logic [CW-1:0]                     out_count;
    logic                              out_empty;

    // Controller.
    deq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_sts   (dp_sts),
        .dp_cmd   (dp_cmd)
    );

    // Datapath.
    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .dp_cmd     (dp_cmd),
        .dp_sts     (dp_sts),
        .in_command (s_tdata[deq_pkg::CMD_W-1:0]),
        .in_data    (s_tdata[deq_pkg::CMD_W + deq_pkg::DATA_W - 1:deq_pkg::CMD_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data),
        .out_status (out_status),
        .out_count  (out_count),
        .out_empty  (out_empty)
    );

    // Pack the result fields, lowest field first, zero filled to whole bytes.
    assign m_tdata = M_W'({out_empty, out_count, out_status, out_data});

endmodule

`default_nettype wire

>>> test/deq_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue result checker
// Watches the request and result channels, keeps its own model of the queue,
// and compares every result field with the oldest expected result.
// ----------------------------------------------------------------------------

module deq_result_checker #(
    parameter int unsigned DEPTH = deq_pkg::DEPTH_DEFAULT,
    parameter int unsigned S_W   = 40,
    parameter int unsigned M_W   = 40
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    // s_tdata: [2:0] command, [34:3] data_in, upper bits zero fill
    input  wire logic [S_W-1:0] s_tdata,
    input  wire logic           s_tvalid,
    input  wire logic           s_tready,
    // m_tdata: [31:0] data_out, [33:32] status, then entry_count, then is_empty
    input  wire logic [M_W-1:0] m_tdata,
    input  wire logic           m_tvalid,
    input  wire logic           m_tready,
    output int unsigned         error_count,
    output int unsigned         pending_count,
    output int unsigned         results_checked,
    output int unsigned         full_refusals,
    output int unsigned         empty_pops
);

    import deq_pkg::*;

    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam int unsigned CNT_LSB = DATA_W + STATUS_W;

    typedef struct packed {
        logic [DATA_W-1:0] data_out;
        status_t           status;
        logic [CNT_W-1:0]  entry_count;
        logic              is_empty;
    } deq_result_t;

    // Shadow copy of the queue.
    logic [DATA_W-1:0] slot_mem [DEPTH];
    int unsigned head_slot;
    int unsigned tail_slot;
    int unsigned fill_level;

    deq_result_t expected_results [$];
    deq_result_t want;
    deq_result_t seen;

    initial begin
        error_count     = 0;
        pending_count   = 0;
        results_checked = 0;
        full_refusals   = 0;
        empty_pops      = 0;
        head_slot       = 0;
        tail_slot       = 0;
        fill_level      = 0;
    end

    // Applies one command to the shadow queue and returns the result it causes.
    function automatic deq_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                  input logic [DATA_W-1:0] value);
        deq_result_t res;
        logic [DATA_W-1:0] popped;
        status_t st;
        popped = '0;
        st = STATUS_OK;
        case (cmd)
            CMD_PUSH_FRONT: begin
                if (fill_level >= DEPTH) begin
                    st = STATUS_FULL;
                end else begin
                    head_slot = (head_slot + DEPTH - 1) % DEPTH;
                    slot_mem[head_slot] = value;
                    fill_level++;
                end
            end
            CMD_PUSH_BACK: begin
                if (fill_level >= DEPTH) begin
                    st = STATUS_FULL;
                end else begin
                    slot_mem[tail_slot] = value;
                    tail_slot = (tail_slot + 1) % DEPTH;
                    fill_level++;
                end
            end
            CMD_POP_FRONT: begin
                if (fill_level == 0) begin
                    st = STATUS_EMPTY;
                end else begin
                    popped = slot_mem[head_slot];
                    head_slot = (head_slot + 1) % DEPTH;
                    fill_level--;
                end
            end
            CMD_POP_BACK: begin
                if (fill_level == 0) begin
                    st = STATUS_EMPTY;
                end else begin
                    tail_slot = (tail_slot + DEPTH - 1) % DEPTH;
                    popped = slot_mem[tail_slot];
                    fill_level--;
                end
            end
            CMD_CLEAR: begin
                head_slot = 0;
                tail_slot = 0;
                fill_level = 0;
            end
            default: begin
                // Codes outside the command set leave the queue alone.
            end
        endcase
        if (st == STATUS_FULL) full_refusals++;
        if (st == STATUS_EMPTY) empty_pops++;
        res.data_out = popped;
        res.status = st;
        res.entry_count = fill_level[CNT_W-1:0];
        res.is_empty = (fill_level == 0);
        return res;
    endfunction

    // Counts a failure and reports the first few in detail.
    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] exp_val,
                                   input logic [DATA_W-1:0] act_val);
        error_count++;
        if (error_count <= 10) begin
            $display("deq checker: %s at result %0d: expected %h, got %h",
                     what, results_checked, exp_val, act_val);
        end
    endtask

    // Predict on each accepted request, compare on each accepted result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            head_slot = 0;
            tail_slot = 0;
            fill_level = 0;
            expected_results.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(apply_command(s_tdata[CMD_W-1:0],
                                                         s_tdata[CMD_W +: DATA_W]));
            end
            if (m_tvalid && m_tready) begin
                seen.data_out = m_tdata[DATA_W-1:0];
                seen.status = status_t'(m_tdata[DATA_W +: STATUS_W]);
                seen.entry_count = m_tdata[CNT_LSB +: CNT_W];
                seen.is_empty = m_tdata[CNT_LSB + CNT_W];
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no request pending", '0, seen.data_out);
                end else begin
                    want = expected_results.pop_front();
                    if (seen.data_out !== want.data_out)
                        report_mismatch("data_out", want.data_out, seen.data_out);
                    if (seen.status !== want.status)
                        report_mismatch("status", DATA_W'(want.status), DATA_W'(seen.status));
                    if (seen.entry_count !== want.entry_count)
                        report_mismatch("entry_count", DATA_W'(want.entry_count),
                                        DATA_W'(seen.entry_count));
                    if (seen.is_empty !== want.is_empty)
                        report_mismatch("is_empty", DATA_W'(want.is_empty),
                                        DATA_W'(seen.is_empty));
                end
                results_checked++;
            end
        end
        pending_count = expected_results.size();
    end

endmodule

>>> test/double_ended_queue_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives directed and random command requests into the queue with random
// gaps on both channels, including one long result hold-off, and leaves the
// checking to the result checker instantiated beside the block.
// ----------------------------------------------------------------------------

module double_ended_queue_top_tb;

    import deq_pkg::*;

    localparam int unsigned DEPTH = DEPTH_DEFAULT;
    localparam int unsigned S_W = ((CMD_W + DATA_W + 7) / 8) * 8;
    localparam int unsigned M_W = ((DATA_W + STATUS_W + $clog2(DEPTH + 1) + 1 + 7) / 8) * 8;
    localparam int unsigned RANDOM_ITEMS = 850;
    localparam int unsigned HOLD_CYCLES = 200;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Codes outside the command set, used to check that they are ignored.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI  = 3'd7;

    typedef enum logic [1:0] {
        FILL_PHASE,
        DRAIN_PHASE,
        MIXED_PHASE
    } phase_t;

    logic           aclk;
    logic           aresetn  = 1'b0;
    logic [S_W-1:0] s_tdata  = '0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [M_W-1:0] m_tdata;
    logic           m_tvalid;
    logic           m_tready = 1'b0;

    // Idle controls shared by the request and result processes.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;
    bit hold_pending = 1'b0;

    int unsigned error_count;
    int unsigned pending_count;
    int unsigned results_checked;
    int unsigned full_refusals;
    int unsigned empty_pops;

    double_ended_queue_top #(
        .DEPTH(DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready)
    );

    deq_result_checker #(
        .DEPTH(DEPTH),
        .S_W  (S_W),
        .M_W  (M_W)
    ) result_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tdata        (s_tdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .m_tdata        (m_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .error_count    (error_count),
        .pending_count  (pending_count),
        .results_checked(results_checked),
        .full_refusals  (full_refusals),
        .empty_pops     (empty_pops)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Push value: mostly random, sometimes one of the extremes.
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 39))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // Command mix leaning toward pushes or pops according to the phase.
    function automatic logic [CMD_W-1:0] pick_command(input phase_t phase);
        int unsigned r;
        int unsigned push_pct;
        int unsigned pop_pct;
        r = $urandom_range(0, 99);
        push_pct = (phase == FILL_PHASE) ? 78 : (phase == DRAIN_PHASE) ? 19 : 49;
        pop_pct = 97 - push_pct;
        if (r < push_pct)
            return $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        if (r < push_pct + pop_pct)
            return $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        if (r < 98)
            return CMD_CLEAR;
        return CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
    endfunction

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        int unsigned gap;
        gap = tx_steady ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {{(S_W - CMD_W - DATA_W){1'b0}}, value, cmd};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Result side: random stalls, steady stretches and one long hold-off.
    initial begin
        int unsigned stall;
        int unsigned held;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
            end else if (rx_steady) begin
                m_tready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (stall - 1) @(posedge aclk);
                end
            end
        end
    end

    // Request side: reset, directed cases, then random phases.
    initial begin
        int unsigned sent;
        int unsigned phase_len;
        int unsigned phase_count;
        int unsigned n;
        phase_t phase;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Pops on an empty queue.
        send_request(CMD_POP_FRONT, pick_value());
        send_request(CMD_POP_BACK, pick_value());
        // Extreme values at both ends, then one pop from each end.
        send_request(CMD_PUSH_FRONT, 32'h8000_0000);
        send_request(CMD_PUSH_BACK, 32'h7fff_ffff);
        send_request(CMD_PUSH_FRONT, 32'hffff_ffff);
        send_request(CMD_PUSH_BACK, 32'h0000_0000);
        send_request(CMD_POP_FRONT, pick_value());
        send_request(CMD_POP_BACK, pick_value());
        // Unknown codes leave the two stored entries in place.
        send_request(CMD_UNKNOWN_LO, pick_value());
        send_request(CMD_UNKNOWN_MID, pick_value());
        send_request(CMD_UNKNOWN_HI, pick_value());
        // Fill to the top, refuse pushes at both ends, then clear.
        for (n = 2; n < DEPTH; n++)
            send_request($urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, pick_value());
        send_request(CMD_PUSH_FRONT, pick_value());
        send_request(CMD_PUSH_BACK, pick_value());
        send_request(CMD_CLEAR, pick_value());

        sent = 0;
        phase_count = 0;
        while (sent < RANDOM_ITEMS) begin
            phase = phase_t'($urandom_range(FILL_PHASE, MIXED_PHASE));
            phase_len = $urandom_range(20, 60);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            // Once, hold the result side off while requests keep coming.
            if (phase_count == 3) begin
                phase = FILL_PHASE;
                tx_steady = 1'b1;
                rx_steady = 1'b0;
                hold_pending = 1'b1;
            end
            for (n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
                send_request(pick_command(phase), pick_value());
                sent++;
            end
            phase_count++;
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("double_ended_queue_top_tb: %0d results checked over %0d random phases,",
                 results_checked, phase_count);
        $display("double_ended_queue_top_tb: %0d pushes refused when full, %0d pops on empty",
                 full_refusals, empty_pops);
        if (error_count == 0) begin
            $display("double_ended_queue_top_tb: done, clean");
        end else begin
            $display("double_ended_queue_top_tb: done, errors");
        end
        $finish;
    end

    // Watchdog for a stuck handshake or a lost result.
    initial begin
        #5_000_000;
        $display("double_ended_queue_top_tb: done, errors");
        $finish;
    end

endmodule
